>>> sv/prefix_trie_engine_core_assert.svh
// Assertion macros for the prefix trie engine core.
// Expects signals named clock and reset in the scope of use.
`ifndef PREFIX_TRIE_ENGINE_CORE_ASSERT_SVH
`define PREFIX_TRIE_ENGINE_CORE_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define PTEC_ASSERT_HOLDS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Consequent must hold at the edge that follows the antecedent.
`define PTEC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/ptec_pkg.sv
// Shared constants, types and helper functions for the prefix trie engine core.
// No dependencies.
package ptec_pkg;

   localparam int MAX_NODES     = 1024;
   localparam int ALPHABET_SIZE = 26;
   localparam int NODE_W        = $clog2(MAX_NODES);
   localparam int FREE_W        = $clog2(MAX_NODES + 1);
   localparam int SLOT_W        = $clog2(ALPHABET_SIZE);
   localparam int LETTER_W      = 5;
   localparam int COUNT_W       = 32;

   typedef logic [NODE_W-1:0]                     node_type;
   typedef logic [FREE_W-1:0]                     free_type;
   typedef logic [SLOT_W-1:0]                     slot_type;
   typedef logic [LETTER_W-1:0]                   letter_type;
   typedef logic [COUNT_W-1:0]                    count_type;
   typedef logic [ALPHABET_SIZE-1:0][NODE_W-1:0]  link_row_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic walk;
      logic update;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic need_update;
      logic last;
   } status_type;

   function automatic count_type sat_inc(input count_type value);
      return (value == '1) ? value : value + COUNT_W'(1);
   endfunction

   function automatic logic letter_in_range(input letter_type letter);
      return int'(letter) < ALPHABET_SIZE;
   endfunction

endpackage

>>> sv/ptec_dp.sv
// Datapath of the prefix trie engine core: link, count and mark memories, walk state.
// Depends on ptec_pkg; driven by ptec_ctrl through cmd_type.
module ptec_dp import ptec_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       req_op,
   input  logic [4:0] req_letter,
   input  logic       req_last,
   output logic [31:0] rsp_prefix_count,
   output logic       rsp_is_word,
   output logic       rsp_status
);

   // memories, one row per node
   link_row_type link_mem [MAX_NODES];
   count_type    cnt_mem  [MAX_NODES];
   logic         mark_mem [MAX_NODES];

   op_type       op_ff;
   letter_type   letter_ff;
   logic         last_ff;

   node_type     cur_ff;
   logic         missed_ff;
   logic         ovf_ff;
   logic         open_ff;
   free_type     free_ff;
   count_type    root_cnt_ff;
   node_type     clr_ff;

   link_row_type link_q_ff;
   count_type    cnt_q_ff;
   logic         mark_q_ff;

   count_type    rsp_prefix_count_ff;
   logic         rsp_is_word_ff;
   logic         rsp_status_ff;

   logic         dropped;
   logic         in_range;
   slot_type     slot;
   node_type     child;
   logic         is_query;
   logic         can_alloc;
   logic         step;
   logic         alloc;
   logic         overflow_now;
   logic         miss_now;
   logic         move;
   node_type     new_cur;
   logic         mark_set;
   link_row_type link_wr_row;
   node_type     rd_addr;
   count_type    count_val;

   always_comb begin
      dropped      = missed_ff | ovf_ff;
      in_range     = letter_in_range(letter_ff);
      slot         = SLOT_W'(letter_ff);
      child        = in_range ? link_q_ff[slot] : '0;
      is_query     = (op_ff == OP_QUERY);
      can_alloc    = (free_ff != FREE_W'(MAX_NODES));
      step         = !dropped && in_range;
      alloc        = step && !is_query && (child == '0) && can_alloc;
      overflow_now = step && !is_query && (child == '0) && !can_alloc;
      miss_now     = step && is_query && (child == '0);
      move         = step && (child != '0);
      if (alloc) begin
         new_cur = free_ff[NODE_W-1:0];
      end else if (move) begin
         new_cur = child;
      end else begin
         new_cur = cur_ff;
      end
      mark_set     = !dropped && !is_query && last_ff && !overflow_now;
      link_wr_row  = link_q_ff;
      if (in_range) begin
         link_wr_row[slot] = free_ff[NODE_W-1:0];
      end
      rd_addr      = cmd.walk ? new_cur : cur_ff;
      // root count lives in a register, not in the count memory
      count_val    = (cur_ff == '0) ? root_cnt_ff : cnt_q_ff;
   end

   assign status.clear_done  = (clr_ff == NODE_W'(MAX_NODES - 1));
   assign status.need_update = step && !is_query && !overflow_now;
   assign status.last        = last_ff;

   // walk state, free pointer, root count and clearing counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff      <= '0;
         missed_ff   <= 1'b0;
         ovf_ff      <= 1'b0;
         open_ff     <= 1'b0;
         free_ff     <= FREE_W'(1);
         root_cnt_ff <= '0;
         clr_ff      <= '0;
      end else begin
         if (cmd.clear) begin
            clr_ff <= clr_ff + NODE_W'(1);
         end
         if (cmd.accept) begin
            if (op_type'(req_op) == OP_INSERT && !open_ff && !dropped) begin
               root_cnt_ff <= sat_inc(root_cnt_ff);
            end
            open_ff <= 1'b1;
         end
         if (cmd.walk) begin
            if (alloc) begin
               free_ff <= free_ff + FREE_W'(1);
            end
            if (miss_now) begin
               missed_ff <= 1'b1;
            end
            if (overflow_now) begin
               ovf_ff <= 1'b1;
            end
            cur_ff <= new_cur;
         end
         // word done: back to the root
         if (cmd.finish) begin
            cur_ff    <= '0;
            missed_ff <= 1'b0;
            ovf_ff    <= 1'b0;
            open_ff   <= 1'b0;
         end
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= op_type'(req_op);
         letter_ff <= req_letter;
         last_ff   <= req_last;
      end
      if (cmd.finish) begin
         if (is_query) begin
            rsp_prefix_count_ff <= dropped ? '0 : count_val;
            rsp_is_word_ff      <= !dropped && mark_q_ff;
            rsp_status_ff       <= 1'b0;
         end else begin
            rsp_prefix_count_ff <= '0;
            rsp_is_word_ff      <= 1'b0;
            rsp_status_ff       <= ovf_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         link_mem[clr_ff] <= '0;
      end else if (cmd.walk && alloc) begin
         link_mem[cur_ff] <= link_wr_row;
      end
      link_q_ff <= link_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         cnt_mem[clr_ff] <= '0;
      end else if (cmd.update) begin
         cnt_mem[cur_ff] <= sat_inc(cnt_q_ff);
      end
      cnt_q_ff <= cnt_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mark_mem[clr_ff] <= 1'b0;
      end else if (cmd.walk && mark_set) begin
         mark_mem[new_cur] <= 1'b1;
      end
      mark_q_ff <= mark_mem[rd_addr];
   end

   assign rsp_prefix_count = rsp_prefix_count_ff;
   assign rsp_is_word      = rsp_is_word_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

>>> sv/ptec_ctrl.sv
// Controller of the prefix trie engine core: sequencing FSM and result valid.
// Depends on ptec_pkg; drives ptec_dp through cmd_type.
module ptec_ctrl import ptec_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.need_update) begin
               state_in = ST_UPDATE;
            end else if (status.last) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.last ? ST_RESULT : ST_IDLE;
         end
         ST_RESULT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/prefix_trie_engine_core.sv
// Channel   Ports                                                         Direction
// req       req_valid req_ready req_op req_letter req_last                in
// rsp       rsp_valid rsp_ready rsp_prefix_count rsp_is_word rsp_status   out
//
// A query letter is accepted, then walked (link row read); an insert letter that counts
// a node adds a count read-modify-write; a last letter then loads the result register.
// After reset a clearing pass zeroes every row of the node memories (MAX_NODES, 1024),
// during which req_ready stays low. A waiting result does not block the next item;
// only a further last letter waits until the result register is taken.
// Top level of the prefix trie engine core; depends on ptec_pkg, ptec_ctrl, ptec_dp.
`include "prefix_trie_engine_core_assert.svh"

module prefix_trie_engine_core import ptec_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [4:0]  req_letter,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_prefix_count,
   output logic        rsp_is_word,
   output logic        rsp_status
);

   cmd_type    cmd;
   status_type status;

   ptec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ptec_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_letter       (req_letter),
      .req_last         (req_last),
      .rsp_prefix_count (rsp_prefix_count),
      .rsp_is_word      (rsp_is_word),
      .rsp_status       (rsp_status)
   );

   `PTEC_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
   `PTEC_ASSERT_HOLDS(a_word_has_count,
      !(rsp_valid && rsp_is_word) || rsp_prefix_count != '0, "word with zero count")
   `PTEC_ASSERT_HOLDS(a_overflow_clean,
      !(rsp_valid && rsp_status) || (!rsp_is_word && rsp_prefix_count == '0),
      "overflow with query data")

endmodule
